>>> hdl/sha256_pkg.sv
// ----------------------------------------------------------------------------
// sha256_pkg
// Shared types, constants and round functions for the SHA-256 digest block.
// ----------------------------------------------------------------------------
`default_nettype none

package sha256_pkg;

    localparam int unsigned Rounds     = 64;

    // one queued block for the compression engine
    typedef struct packed {
        logic [511:0] block;     // big-endian, word 0 in bits 511:480
        logic         finish;    // last block of a message
    } t_blk;

    typedef logic [255:0] t_hash;

    localparam t_hash HashInit = {
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [7:0] PadMark = 8'h80;

    function automatic logic [31:0] round_k(input logic [5:0] t);
        logic [31:0] k;
        unique case (t)
            6'd0:  k = 32'h428a2f98;  6'd1:  k = 32'h71374491;
            6'd2:  k = 32'hb5c0fbcf;  6'd3:  k = 32'he9b5dba5;
            6'd4:  k = 32'h3956c25b;  6'd5:  k = 32'h59f111f1;
            6'd6:  k = 32'h923f82a4;  6'd7:  k = 32'hab1c5ed5;
            6'd8:  k = 32'hd807aa98;  6'd9:  k = 32'h12835b01;
            6'd10: k = 32'h243185be;  6'd11: k = 32'h550c7dc3;
            6'd12: k = 32'h72be5d74;  6'd13: k = 32'h80deb1fe;
            6'd14: k = 32'h9bdc06a7;  6'd15: k = 32'hc19bf174;
            6'd16: k = 32'he49b69c1;  6'd17: k = 32'hefbe4786;
            6'd18: k = 32'h0fc19dc6;  6'd19: k = 32'h240ca1cc;
            6'd20: k = 32'h2de92c6f;  6'd21: k = 32'h4a7484aa;
            6'd22: k = 32'h5cb0a9dc;  6'd23: k = 32'h76f988da;
            6'd24: k = 32'h983e5152;  6'd25: k = 32'ha831c66d;
            6'd26: k = 32'hb00327c8;  6'd27: k = 32'hbf597fc7;
            6'd28: k = 32'hc6e00bf3;  6'd29: k = 32'hd5a79147;
            6'd30: k = 32'h06ca6351;  6'd31: k = 32'h14292967;
            6'd32: k = 32'h27b70a85;  6'd33: k = 32'h2e1b2138;
            6'd34: k = 32'h4d2c6dfc;  6'd35: k = 32'h53380d13;
            6'd36: k = 32'h650a7354;  6'd37: k = 32'h766a0abb;
            6'd38: k = 32'h81c2c92e;  6'd39: k = 32'h92722c85;
            6'd40: k = 32'ha2bfe8a1;  6'd41: k = 32'ha81a664b;
            6'd42: k = 32'hc24b8b70;  6'd43: k = 32'hc76c51a3;
            6'd44: k = 32'hd192e819;  6'd45: k = 32'hd6990624;
            6'd46: k = 32'hf40e3585;  6'd47: k = 32'h106aa070;
            6'd48: k = 32'h19a4c116;  6'd49: k = 32'h1e376c08;
            6'd50: k = 32'h2748774c;  6'd51: k = 32'h34b0bcb5;
            6'd52: k = 32'h391c0cb3;  6'd53: k = 32'h4ed8aa4a;
            6'd54: k = 32'h5b9cca4f;  6'd55: k = 32'h682e6ff3;
            6'd56: k = 32'h748f82ee;  6'd57: k = 32'h78a5636f;
            6'd58: k = 32'h84c87814;  6'd59: k = 32'h8cc70208;
            6'd60: k = 32'h90befffa;  6'd61: k = 32'ha4506ceb;
            6'd62: k = 32'hbef9a3f7;  6'd63: k = 32'hc67178f2;
            default: k = 32'h0;
        endcase
        return k;
    endfunction

    function automatic logic [31:0] ror(input logic [31:0] x, input int unsigned n);
        return (x >> n) | (x << (32 - n));
    endfunction

endpackage

`default_nettype wire

>>> hdl/sha256_message_digest_top.sv
// ----------------------------------------------------------------------------
// sha256_message_digest_top
// Byte-stream SHA-256: message bytes in, one 256-bit digest out per message.
// ----------------------------------------------------------------------------
// Channel  Dir  tdata                          tuser / tlast
// s_axis   in   [7:0] data_byte                tuser=byte_valid, tlast=last_byte
// m_axis   out  [255:0] digest_part_0..3       -
//
// Bytes enter at one per cycle while a block gathers and the front is not
// holding a block. Each full or padding block goes through a two-deep queue
// to the round engine, which loads it, runs 64 rounds and sums before the next.
// Sustained rate is about one byte per cycle; spilling padding adds a block.
// Synchronous active-low reset restores the initial hash and an empty block.
// A stalled m_axis holds the digest and the engine; the front keeps taking
// bytes until the queue fills.
// ----------------------------------------------------------------------------
`default_nettype none

module sha256_message_digest_top (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    input  wire logic [7:0]   s_axis_tdata,   // [7:0] data_byte
    input  wire logic         s_axis_tuser,   // [0] byte_valid
    input  wire logic         s_axis_tlast,
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // [63:0] digest_part_0, [127:64] part_1, [191:128] part_2, [255:192] part_3
    output logic [255:0]      m_axis_tdata
);
    import sha256_pkg::*;

    t_blk  f_blk, q_blk;
    logic  f_v, f_r, q_v, q_r;
    t_hash hash;

    sha256_front u_front (
        .i_clk, .i_rst_n,
        .i_valid(s_axis_tvalid), .o_ready(s_axis_tready),
        .i_data(s_axis_tdata), .i_byte_valid(s_axis_tuser), .i_last(s_axis_tlast),
        .o_blk_valid(f_v), .i_blk_ready(f_r), .o_blk(f_blk)
    );

    sha256_queue u_queue (
        .i_clk, .i_rst_n,
        .i_valid(f_v), .o_ready(f_r), .i_blk(f_blk),
        .o_valid(q_v), .i_ready(q_r), .o_blk(q_blk)
    );

    sha256_engine u_engine (
        .i_clk, .i_rst_n,
        .i_valid(q_v), .o_ready(q_r), .i_blk(q_blk),
        .o_valid(m_axis_tvalid), .i_ready(m_axis_tready), .o_hash(hash)
    );

    // hash word 0 is most significant; part_0 sits in the low tdata bits
    assign m_axis_tdata = {hash[63:0], hash[127:64], hash[191:128], hash[255:192]};

endmodule

`default_nettype wire

>>> hdl/sha256_front.sv
// ----------------------------------------------------------------------------
// sha256_front
// Gathers message bytes into 64-byte blocks and builds the padding blocks.
// ----------------------------------------------------------------------------
`default_nettype none

module sha256_front (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    output logic                   o_ready,
    input  wire logic [7:0]        i_data,
    input  wire logic              i_byte_valid,
    input  wire logic              i_last,
    output logic                   o_blk_valid,
    input  wire logic              i_blk_ready,
    output sha256_pkg::t_blk       o_blk
);
    import sha256_pkg::*;

    logic [511:0] r_buf,   n_buf;
    logic [5:0]   r_fill,  n_fill;
    logic [63:0]  r_bits,  n_bits;
    logic         r_extra, n_extra;     // length block still to go out
    logic         r_ov,    n_ov;
    t_blk         r_out,   n_out;
    logic         r_out_v, n_out_v;

    logic         free;
    logic [511:0] wbuf;
    logic [5:0]   wfill;
    logic [63:0]  wbits;
    logic [6:0]   wcount;

    // output holding register empties when taken
    assign free    = !r_out_v || i_blk_ready;
    assign o_ready = free && !r_extra;
    assign o_blk_valid = r_out_v;
    assign o_blk       = r_out;

    always_comb begin
        n_buf = r_buf; n_fill = r_fill; n_bits = r_bits; n_extra = r_extra;
        n_ov = r_ov;
        n_out = r_out;
        n_out_v = r_out_v && !i_blk_ready;
        wbuf = r_buf; wfill = r_fill; wbits = r_bits;
        wcount = {1'b0, r_fill};
        if (free && r_extra) begin
            // second padding block: zeros (or the marker) then the length
            n_out.block = {448'b0, r_bits};
            if (!r_ov) n_out.block[511:504] = PadMark;
            n_out.finish = 1'b1;
            n_out_v = 1'b1;
            n_extra = 1'b0;
            n_bits = '0; n_fill = '0;
        end else if (i_valid && o_ready) begin
            if (i_byte_valid) begin
                wbuf[511 - 8*r_fill -: 8] = i_data;
                wbits  = r_bits + 64'd8;
                wcount = {1'b0, r_fill} + 7'd1;
                wfill  = wcount[5:0];
            end
            n_buf = wbuf; n_fill = wfill; n_bits = wbits;
            if (wcount == 7'd64) begin
                n_out.block = wbuf;
                n_out.finish = 1'b0;
                n_out_v = 1'b1;
                if (i_last) begin
                    // marker goes into a fresh block
                    n_extra = 1'b1; n_ov = 1'b0;
                end
            end else if (i_last) begin
                n_out.block = wbuf;
                n_out.block[511 - 8*wfill -: 8] = PadMark;
                for (int j = 0; j < 64; j++) begin
                    if (j > wfill) n_out.block[511 - 8*j -: 8] = 8'h00;
                end
                if (wfill < 6'd56) begin
                    n_out.block[63:0] = wbits;
                    n_out.finish = 1'b1;
                    n_bits = '0; n_fill = '0;
                end else begin
                    n_out.finish = 1'b0;
                    n_extra = 1'b1; n_ov = 1'b1;
                end
                n_out_v = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0; r_bits <= '0; r_extra <= 1'b0; r_out_v <= 1'b0;
        end else begin
            r_fill <= n_fill; r_bits <= n_bits; r_extra <= n_extra;
            r_out_v <= n_out_v;
        end
        r_buf <= n_buf; r_out <= n_out; r_ov <= n_ov;
    end

endmodule

`default_nettype wire

>>> hdl/sha256_queue.sv
// ----------------------------------------------------------------------------
// sha256_queue
// Two-entry block queue between the byte front end and the round engine.
// ----------------------------------------------------------------------------
`default_nettype none

module sha256_queue (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    output logic                   o_ready,
    input  sha256_pkg::t_blk       i_blk,
    output logic                   o_valid,
    input  wire logic              i_ready,
    output sha256_pkg::t_blk       o_blk
);
    import sha256_pkg::*;

    t_blk       r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       push, pop;

    assign o_ready = r_cnt != 2'd2;
    assign o_valid = r_cnt != 2'd0;
    assign o_blk   = r_mem[r_rp];
    assign push    = i_valid && o_ready;
    assign pop     = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= 1'b0; r_rp <= 1'b0; r_cnt <= '0;
        end else begin
            if (push) r_wp <= !r_wp;
            if (pop)  r_rp <= !r_rp;
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, pop};
        end
        if (push) r_mem[r_wp] <= i_blk;
    end

endmodule

`default_nettype wire

>>> hdl/sha256_engine.sv
// ----------------------------------------------------------------------------
// sha256_engine
// One SHA-256 round per cycle over a 16-word rolling schedule window.
// ----------------------------------------------------------------------------
`default_nettype none

module sha256_engine (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    output logic                   o_ready,
    input  sha256_pkg::t_blk       i_blk,
    output logic                   o_valid,
    input  wire logic              i_ready,
    output sha256_pkg::t_hash      o_hash
);
    import sha256_pkg::*;

    localparam logic [1:0] StIdle = 2'd0, StRound = 2'd1, StSum = 2'd2, StOut = 2'd3;

    logic [1:0]   r_st;
    logic [5:0]   r_t;
    logic [511:0] r_w;
    logic [31:0]  r_a, r_b, r_c, r_d, r_e, r_f, r_g, r_h;
    t_hash        r_hash;
    logic         r_fin;

    logic [31:0] w0, w1, w9, w14, s0, s1, wnext, big0, big1, ch, maj, t1, t2;

    assign w0  = r_w[511:480];
    assign w1  = r_w[479:448];
    assign w9  = r_w[223:192];
    assign w14 = r_w[63:32];
    assign s0  = ror(w1, 7) ^ ror(w1, 18) ^ (w1 >> 3);
    assign s1  = ror(w14, 17) ^ ror(w14, 19) ^ (w14 >> 10);
    assign wnext = w0 + s0 + w9 + s1;
    assign big1 = ror(r_e, 6) ^ ror(r_e, 11) ^ ror(r_e, 25);
    assign ch   = (r_e & r_f) ^ (~r_e & r_g);
    assign t1   = r_h + big1 + ch + round_k(r_t) + w0;
    assign big0 = ror(r_a, 2) ^ ror(r_a, 13) ^ ror(r_a, 22);
    assign maj  = (r_a & r_b) ^ (r_a & r_c) ^ (r_b & r_c);
    assign t2   = big0 + maj;

    assign o_ready = r_st == StIdle;
    assign o_valid = r_st == StOut;
    assign o_hash  = r_hash;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= StIdle; r_hash <= HashInit;
        end else begin
            unique case (r_st)
                StIdle: if (i_valid) begin
                    r_w <= i_blk.block; r_fin <= i_blk.finish; r_t <= '0;
                    {r_a, r_b, r_c, r_d, r_e, r_f, r_g, r_h} <= r_hash;
                    r_st <= StRound;
                end
                StRound: begin
                    r_w <= {r_w[479:0], wnext};
                    r_h <= r_g; r_g <= r_f; r_f <= r_e; r_e <= r_d + t1;
                    r_d <= r_c; r_c <= r_b; r_b <= r_a; r_a <= t1 + t2;
                    r_t <= r_t + 6'd1;
                    if (r_t == 6'(Rounds - 1)) r_st <= StSum;
                end
                StSum: begin
                    r_hash <= {r_hash[255:224] + r_a, r_hash[223:192] + r_b,
                               r_hash[191:160] + r_c, r_hash[159:128] + r_d,
                               r_hash[127:96] + r_e,  r_hash[95:64] + r_f,
                               r_hash[63:32] + r_g,   r_hash[31:0] + r_h};
                    r_st <= r_fin ? StOut : StIdle;
                end
                StOut: if (i_ready) begin
                    r_hash <= HashInit;
                    r_st <= StIdle;
                end
                default: r_st <= StIdle;
            endcase
        end
    end

endmodule

`default_nettype wire

>>> hdl/sha256_checker.sv
// ----------------------------------------------------------------------------
// sha256_checker
// Port-level checks on the digest block.
// ----------------------------------------------------------------------------
`default_nettype none

module sha256_checker (
    input wire logic         i_clk,
    input wire logic         i_rst_n,
    input wire logic         m_axis_tvalid,
    input wire logic         m_axis_tready,
    input wire logic [255:0] m_axis_tdata
);
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("digest dropped while stalled");

    a_known: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !$isunknown(m_axis_tdata))
        else $error("unknown bits in digest");

    a_rst: assert property (@(posedge i_clk) !i_rst_n |=> !m_axis_tvalid)
        else $error("digest valid after reset");

    a_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tready |=> !m_axis_tvalid)
        else $error("back-to-back digests");
endmodule

bind sha256_message_digest_top sha256_checker u_chk (
    .i_clk, .i_rst_n, .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
);

`default_nettype wire
